/* rtl/json_type_key_extractor_assert.svh */
// assertion macros used by the extractor's emitter
`ifndef JSON_TYPE_KEY_EXTRACTOR_ASSERT_SVH
`define JSON_TYPE_KEY_EXTRACTOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define JTKE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define JTKE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/jtke_pkg.sv */
package jtke_pkg;

    // width of capture counts, value capacity and buffer addresses
    localparam int CNT_W = 6;

    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_RBRACE = 8'h7d;
    localparam logic [7:0] CH_LBRACK = 8'h5b;
    localparam logic [7:0] CH_RBRACK = 8'h5d;
    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;

    // key spelled "type"
    localparam logic [7:0] KEY_WORD [4] = '{8'h74, 8'h79, 8'h70, 8'h65};
    localparam logic [2:0] KEY_LEN = 3'd4;

    // status codes
    localparam logic STAT_FOUND     = 1'b0;
    localparam logic STAT_NOT_FOUND = 1'b1;

    // result kinds
    localparam logic KIND_CHAR   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // result job from the parser to the emitter
    typedef struct packed {
        logic             valid;
        logic             is_dump;
        logic             code;
        logic [CNT_W-1:0] count;
    } job_t;

    // capture buffer write
    typedef struct packed {
        logic             en;
        logic [CNT_W-1:0] addr;
        logic [7:0]       data;
    } wr_t;

    function automatic logic is_space(input logic [7:0] b);
        return b inside {8'h20, 8'h09, 8'h0a, 8'h0d};
    endfunction

endpackage

/* rtl/jtke_in_if.sv */
interface jtke_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_byte;

    modport source (output valid, output in_byte, output last_byte, input ready);
    modport sink (input valid, input in_byte, input last_byte, output ready);
endinterface

/* rtl/jtke_out_if.sv */
interface jtke_out_if;
    logic       valid;
    logic       ready;
    logic       out_kind;
    logic [7:0] value_char;
    logic       status_code;
    logic       run_end;

    modport source (output valid, output out_kind, output value_char, output status_code,
                    output run_end, input ready);
    modport sink (input valid, input out_kind, input value_char, input status_code,
                  input run_end, output ready);
endinterface

/* rtl/jtke_emitter.sv */
`include "json_type_key_extractor_assert.svh"

module jtke_emitter #(
    parameter int VALUE_MAX = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  jtke_pkg::wr_t wr,
    input  jtke_pkg::job_t job_in,
    output logic          busy,
    jtke_out_if.source    out_ch
);

    localparam int AW = (VALUE_MAX > 1) ? $clog2(VALUE_MAX) : 1;

    // captured value bytes, no reset
    logic [7:0] mem [VALUE_MAX];

    logic                       job_valid_reg, job_valid_next;
    jtke_pkg::job_t             job_reg;
    logic [jtke_pkg::CNT_W-1:0] idx_reg, idx_next;
    logic [7:0]                 rd_data_reg;
    logic                       out_valid_reg, out_valid_next;
    logic                       out_kind_reg, status_code_reg, run_end_reg;
    logic [7:0]                 value_char_reg;

    logic out_free;
    logic load_char;
    logic load_status;

    assign out_free = !out_valid_reg || out_ch.ready;
    assign busy     = job_valid_reg;

    // pick the next word for the output register
    always_comb
    begin
        load_char   = 1'b0;
        load_status = 1'b0;
        idx_next    = idx_reg;
        if (job_valid_reg && out_free)
        begin
            if (job_reg.is_dump && (idx_reg < job_reg.count))
            begin
                load_char = 1'b1;
                idx_next  = idx_reg + 1'b1;
            end
            else
            begin
                load_status = 1'b1;
                idx_next    = '0;
            end
        end
        job_valid_next = load_status ? 1'b0 : job_valid_reg;
        if (job_in.valid)
        begin
            job_valid_next = 1'b1;
        end
        if (load_char || load_status)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && !out_ch.ready;
        end
    end

    // buffer write and prefetching read of the next byte to emit
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr[AW-1:0]] <= wr.data;
        end
        rd_data_reg <= mem[idx_next[AW-1:0]];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // job and output payload
    always_ff @(posedge clk)
    begin
        if (job_in.valid)
        begin
            job_reg <= job_in;
        end
        if (load_char)
        begin
            out_kind_reg    <= jtke_pkg::KIND_CHAR;
            value_char_reg  <= rd_data_reg;
            status_code_reg <= jtke_pkg::STAT_FOUND;
            run_end_reg     <= 1'b0;
        end
        else if (load_status)
        begin
            out_kind_reg    <= jtke_pkg::KIND_STATUS;
            value_char_reg  <= 8'h00;
            status_code_reg <= job_reg.code;
            run_end_reg     <= 1'b1;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.out_kind    = out_kind_reg;
    assign out_ch.value_char  = value_char_reg;
    assign out_ch.status_code = status_code_reg;
    assign out_ch.run_end     = run_end_reg;

    `JTKE_ASSERT_NOW(a_idx_in_range, job_valid_reg && job_reg.is_dump, idx_reg <= job_reg.count, "dump index past count")
    `JTKE_ASSERT_NEXT(a_status_ends_job, load_status, !job_valid_reg, "job still pending after status")
    `JTKE_ASSERT_NOW(a_no_write_in_dump, wr.en, !job_valid_reg, "buffer written during pending job")

endmodule

/* rtl/json_type_key_extractor.sv */
// results: a result is held in the emitter's job register, then loaded into the output register
// found: buffered value bytes follow one per cycle unless output stalls, then the status word
// throughput: one byte per cycle; a byte with results holds input until its last result is
//   loaded, one value byte at a time through the single buffer read port
// reset: parser returns to frame start, capacity to 32; capture buffer is not cleared
module json_type_key_extractor #(
    parameter int VALUE_MAX = 32,
    parameter int DEPTH_MAX = 255
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [jtke_pkg::CNT_W-1:0] cfg_data,
    jtke_in_if.sink                    in_ch,
    jtke_out_if.source                 out_ch
);

    localparam int CW = jtke_pkg::CNT_W;
    localparam int DW = $clog2(DEPTH_MAX + 1);

    typedef enum logic [3:0] {
        PH_START, PH_KEY_WS, PH_KEY, PH_COLON, PH_VAL_WS, PH_SKIP_STR,
        PH_SKIP_SCALAR, PH_NEST, PH_NEST_STR, PH_AFTER_VAL, PH_CAPTURE
    } phase_t;

    typedef enum logic [1:0] {ADV_MORE, ADV_FOUND, ADV_FAIL} adv_t;

    phase_t          phase_reg, phase_next;
    logic [DW-1:0]   depth_reg, depth_next;
    logic            brace_reg, brace_next;
    logic            esc_reg, esc_next;
    logic [2:0]      match_reg, match_next;
    logic            mismatch_reg, mismatch_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            resolved_reg, resolved_next;
    logic [CW-1:0]   cap_reg;

    adv_t            adv;
    logic            acc;
    logic            busy;
    logic [7:0]      b;
    logic [7:0]      opener, closer;
    logic [CW-1:0]   cap_eff, limit, k;
    logic            store;
    jtke_pkg::job_t  job;
    jtke_pkg::wr_t   wr;

    assign in_ch.ready = !busy;
    assign acc         = in_ch.valid && in_ch.ready;
    assign b           = in_ch.in_byte;
    assign opener      = brace_reg ? jtke_pkg::CH_LBRACE : jtke_pkg::CH_LBRACK;
    assign closer      = brace_reg ? jtke_pkg::CH_RBRACE : jtke_pkg::CH_RBRACK;
    assign cap_eff     = (cap_reg > CW'(VALUE_MAX)) ? CW'(VALUE_MAX) : cap_reg;
    assign limit       = cap_eff - 1'b1;
    assign k           = (count_reg > limit) ? limit : count_reg;
    assign store       = (({1'b0, count_reg} + 1'b1) < {1'b0, cap_eff})
                         && (count_reg < CW'(VALUE_MAX));

    // one parser step per byte
    always_comb
    begin
        phase_next    = phase_reg;
        depth_next    = depth_reg;
        brace_next    = brace_reg;
        esc_next      = esc_reg;
        match_next    = match_reg;
        mismatch_next = mismatch_reg;
        count_next    = count_reg;
        resolved_next = resolved_reg;
        adv           = ADV_MORE;
        wr            = '0;
        job           = '0;
        if (!resolved_reg)
        begin
            if (cap_reg == '0)
            begin
                adv = ADV_FAIL;
            end
            else
            begin
                case (phase_reg)
                    PH_START:
                    begin
                        if (b == jtke_pkg::CH_LBRACE)
                            phase_next = PH_KEY_WS;
                        else if (!jtke_pkg::is_space(b))
                            adv = ADV_FAIL;
                    end
                    PH_KEY_WS, PH_AFTER_VAL:
                    begin
                        if (b == jtke_pkg::CH_QUOTE)
                        begin
                            phase_next    = PH_KEY;
                            esc_next      = 1'b0;
                            match_next    = '0;
                            mismatch_next = 1'b0;
                        end
                        else if (phase_reg == PH_AFTER_VAL && b == jtke_pkg::CH_COMMA)
                            phase_next = PH_KEY_WS;
                        else if (!jtke_pkg::is_space(b))
                            adv = ADV_FAIL;
                    end
                    PH_KEY:
                    begin
                        if (!esc_reg && b == jtke_pkg::CH_QUOTE)
                            phase_next = PH_COLON;
                        else
                        begin
                            if (esc_reg)
                                esc_next = 1'b0;
                            else if (b == jtke_pkg::CH_BSLASH)
                                esc_next = 1'b1;
                            if (match_reg < jtke_pkg::KEY_LEN
                                && b == jtke_pkg::KEY_WORD[match_reg[1:0]])
                                match_next = match_reg + 1'b1;
                            else
                                mismatch_next = 1'b1;
                        end
                    end
                    PH_COLON:
                    begin
                        if (b == jtke_pkg::CH_COLON)
                            phase_next = PH_VAL_WS;
                        else if (!jtke_pkg::is_space(b))
                            adv = ADV_FAIL;
                    end
                    PH_VAL_WS:
                    begin
                        if (!jtke_pkg::is_space(b))
                        begin
                            esc_next = 1'b0;
                            if (match_reg == jtke_pkg::KEY_LEN && !mismatch_reg)
                            begin
                                if (b != jtke_pkg::CH_QUOTE)
                                    adv = ADV_FAIL;
                                else
                                begin
                                    count_next = '0;
                                    phase_next = PH_CAPTURE;
                                end
                            end
                            else if (b == jtke_pkg::CH_QUOTE)
                                phase_next = PH_SKIP_STR;
                            else if (b == jtke_pkg::CH_LBRACE || b == jtke_pkg::CH_LBRACK)
                            begin
                                brace_next = (b == jtke_pkg::CH_LBRACE);
                                depth_next = DW'(1);
                                phase_next = PH_NEST;
                            end
                            else if (b == jtke_pkg::CH_COMMA)
                                phase_next = PH_KEY_WS;
                            else if (b == jtke_pkg::CH_RBRACE)
                                adv = ADV_FAIL;
                            else
                                phase_next = PH_SKIP_SCALAR;
                        end
                    end
                    PH_SKIP_STR, PH_NEST_STR:
                    begin
                        if (esc_reg)
                            esc_next = 1'b0;
                        else if (b == jtke_pkg::CH_BSLASH)
                            esc_next = 1'b1;
                        else if (b == jtke_pkg::CH_QUOTE)
                            phase_next = (phase_reg == PH_SKIP_STR) ? PH_AFTER_VAL : PH_NEST;
                    end
                    PH_SKIP_SCALAR:
                    begin
                        if (b == jtke_pkg::CH_COMMA)
                            phase_next = PH_KEY_WS;
                        else if (b == jtke_pkg::CH_RBRACE)
                            adv = ADV_FAIL;
                        else if (jtke_pkg::is_space(b))
                            phase_next = PH_AFTER_VAL;
                    end
                    PH_NEST:
                    begin
                        if (b == jtke_pkg::CH_QUOTE)
                        begin
                            esc_next   = 1'b0;
                            phase_next = PH_NEST_STR;
                        end
                        else if (b == opener)
                        begin
                            if (depth_reg >= DW'(DEPTH_MAX))
                                adv = ADV_FAIL;
                            else
                                depth_next = depth_reg + 1'b1;
                        end
                        else if (b == closer)
                        begin
                            if (depth_reg <= DW'(1))
                            begin
                                depth_next = '0;
                                phase_next = PH_AFTER_VAL;
                            end
                            else
                                depth_next = depth_reg - 1'b1;
                        end
                    end
                    PH_CAPTURE:
                    begin
                        if (!esc_reg && b == jtke_pkg::CH_QUOTE)
                            adv = ADV_FOUND;
                        else
                        begin
                            if (esc_reg)
                                esc_next = 1'b0;
                            else if (b == jtke_pkg::CH_BSLASH)
                                esc_next = 1'b1;
                            if (store)
                            begin
                                wr.en      = acc;
                                wr.addr    = count_reg;
                                wr.data    = b;
                                count_next = count_reg + 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        adv = ADV_FAIL;
                    end
                endcase
            end
        end

        // results of this byte
        if (adv == ADV_FOUND)
        begin
            job.valid     = acc;
            job.is_dump   = 1'b1;
            job.code      = jtke_pkg::STAT_FOUND;
            job.count     = k;
            resolved_next = 1'b1;
        end
        else if (adv == ADV_FAIL)
        begin
            job.valid     = acc;
            job.code      = jtke_pkg::STAT_NOT_FOUND;
            resolved_next = 1'b1;
        end

        // frame end: report if unresolved, then back to frame start
        if (in_ch.last_byte)
        begin
            if (!resolved_next)
            begin
                job.valid = acc;
                job.code  = jtke_pkg::STAT_NOT_FOUND;
            end
            phase_next    = PH_START;
            depth_next    = '0;
            brace_next    = 1'b0;
            esc_next      = 1'b0;
            match_next    = '0;
            mismatch_next = 1'b0;
            count_next    = '0;
            resolved_next = 1'b0;
        end
    end

    // parser state and capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_START;
            depth_reg    <= '0;
            brace_reg    <= 1'b0;
            esc_reg      <= 1'b0;
            match_reg    <= '0;
            mismatch_reg <= 1'b0;
            count_reg    <= '0;
            resolved_reg <= 1'b0;
            cap_reg      <= CW'(32);
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
            if (acc)
            begin
                phase_reg    <= phase_next;
                depth_reg    <= depth_next;
                brace_reg    <= brace_next;
                esc_reg      <= esc_next;
                match_reg    <= match_next;
                mismatch_reg <= mismatch_next;
                count_reg    <= count_next;
                resolved_reg <= resolved_next;
            end
        end
    end

    // capture buffer and result sequencing
    jtke_emitter #(
        .VALUE_MAX (VALUE_MAX)
    ) u_emitter (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (wr),
        .job_in (job),
        .busy   (busy),
        .out_ch (out_ch)
    );

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;

    localparam int BUF_MAX = 32;
    localparam int NEST_MAX = 255;
    localparam int KEY_CHARS = 4;
    localparam int IDLE_PCT = 9;
    localparam int CYCLE_LIMIT = 400000;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF = 8'h0a;
    localparam logic [7:0] CH_CR = 8'h0d;

    typedef enum logic [3:0] {
        PH_OPEN,
        PH_KEY_GAP,
        PH_KEY,
        PH_COLON,
        PH_VALUE_GAP,
        PH_SKIP_STR,
        PH_SKIP_SCALAR,
        PH_NEST,
        PH_NEST_STR,
        PH_AFTER_VALUE,
        PH_CAPTURE
    } phase_e;

    typedef enum logic [1:0] {
        SCAN_MORE,
        SCAN_FOUND,
        SCAN_FAIL
    } scan_e;

    typedef struct packed {
        logic       kind;
        logic [7:0] ch;
        logic       code;
        logic       closing;
    } word_t;

    // tracks the type-key parse of the current frame and the words it must produce
    class extract_scoreboard;
        word_t       expected_words[$];
        int          errors;
        int          predicted;
        int unsigned capacity;
        phase_e      phase;
        int unsigned depth;
        bit          brace_open;
        bit          escaped;
        bit          key_bad;
        bit          resolved;
        int unsigned key_hits;
        int unsigned value_len;
        logic [7:0]  value_buf [BUF_MAX];

        function new();
            capacity = 32;
            errors = 0;
            predicted = 0;
            restart();
        endfunction

        function void restart();
            phase = PH_OPEN;
            depth = 0;
            brace_open = 1'b0;
            escaped = 1'b0;
            key_hits = 0;
            key_bad = 1'b0;
            value_len = 0;
            resolved = 1'b0;
        endfunction

        function bit blank(logic [7:0] b);
            return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR;
        endfunction

        function int unsigned usable();
            return (capacity > BUF_MAX) ? BUF_MAX : capacity;
        endfunction

        function void open_key();
            phase = PH_KEY;
            escaped = 1'b0;
            key_hits = 0;
            key_bad = 1'b0;
        endfunction

        function void add_word(logic kind, logic [7:0] ch, logic code, logic closing);
            expected_words.push_back(word_t'{kind, ch, code, closing});
            predicted++;
        endfunction

        // one parser step on a byte of an unresolved frame
        function scan_e scan(logic [7:0] b);
            scan_e      r;
            logic [7:0] opener;
            logic [7:0] closer;
            r = SCAN_MORE;
            opener = brace_open ? jtke_pkg::CH_LBRACE : jtke_pkg::CH_LBRACK;
            closer = brace_open ? jtke_pkg::CH_RBRACE : jtke_pkg::CH_RBRACK;
            case (phase)
                PH_OPEN:
                begin
                    if (!blank(b))
                    begin
                        if (b == jtke_pkg::CH_LBRACE) phase = PH_KEY_GAP;
                        else r = SCAN_FAIL;
                    end
                end
                PH_KEY_GAP:
                begin
                    if (!blank(b))
                    begin
                        if (b == jtke_pkg::CH_QUOTE) open_key();
                        else r = SCAN_FAIL;
                    end
                end
                PH_KEY:
                begin
                    if (!escaped && b == jtke_pkg::CH_QUOTE)
                        phase = PH_COLON;
                    else
                    begin
                        if (escaped) escaped = 1'b0;
                        else if (b == jtke_pkg::CH_BSLASH) escaped = 1'b1;
                        if (key_hits < KEY_CHARS
                            && b == jtke_pkg::KEY_WORD[key_hits[1:0]])
                            key_hits++;
                        else
                            key_bad = 1'b1;
                    end
                end
                PH_COLON:
                begin
                    if (!blank(b))
                    begin
                        if (b == jtke_pkg::CH_COLON) phase = PH_VALUE_GAP;
                        else r = SCAN_FAIL;
                    end
                end
                PH_VALUE_GAP:
                begin
                    if (!blank(b))
                    begin
                        escaped = 1'b0;
                        if (key_hits == KEY_CHARS && !key_bad)
                        begin
                            if (b == jtke_pkg::CH_QUOTE)
                            begin
                                value_len = 0;
                                phase = PH_CAPTURE;
                            end
                            else
                                r = SCAN_FAIL;
                        end
                        else if (b == jtke_pkg::CH_QUOTE)
                            phase = PH_SKIP_STR;
                        else if (b == jtke_pkg::CH_LBRACE || b == jtke_pkg::CH_LBRACK)
                        begin
                            brace_open = (b == jtke_pkg::CH_LBRACE);
                            depth = 1;
                            phase = PH_NEST;
                        end
                        else if (b == jtke_pkg::CH_COMMA)
                            phase = PH_KEY_GAP;
                        else if (b == jtke_pkg::CH_RBRACE)
                            r = SCAN_FAIL;
                        else
                            phase = PH_SKIP_SCALAR;
                    end
                end
                PH_SKIP_STR:
                begin
                    if (escaped) escaped = 1'b0;
                    else if (b == jtke_pkg::CH_BSLASH) escaped = 1'b1;
                    else if (b == jtke_pkg::CH_QUOTE) phase = PH_AFTER_VALUE;
                end
                PH_SKIP_SCALAR:
                begin
                    if (b == jtke_pkg::CH_COMMA) phase = PH_KEY_GAP;
                    else if (b == jtke_pkg::CH_RBRACE) r = SCAN_FAIL;
                    else if (blank(b)) phase = PH_AFTER_VALUE;
                end
                PH_NEST:
                begin
                    if (b == jtke_pkg::CH_QUOTE)
                    begin
                        escaped = 1'b0;
                        phase = PH_NEST_STR;
                    end
                    else if (b == opener)
                    begin
                        if (depth >= NEST_MAX) r = SCAN_FAIL;
                        else depth++;
                    end
                    else if (b == closer)
                    begin
                        if (depth > 0) depth--;
                        if (depth == 0) phase = PH_AFTER_VALUE;
                    end
                end
                PH_NEST_STR:
                begin
                    if (escaped) escaped = 1'b0;
                    else if (b == jtke_pkg::CH_BSLASH) escaped = 1'b1;
                    else if (b == jtke_pkg::CH_QUOTE) phase = PH_NEST;
                end
                PH_AFTER_VALUE:
                begin
                    if (!blank(b))
                    begin
                        if (b == jtke_pkg::CH_COMMA) phase = PH_KEY_GAP;
                        else if (b == jtke_pkg::CH_QUOTE) open_key();
                        else r = SCAN_FAIL;
                    end
                end
                PH_CAPTURE:
                begin
                    if (!escaped && b == jtke_pkg::CH_QUOTE)
                        r = SCAN_FOUND;
                    else
                    begin
                        if (escaped) escaped = 1'b0;
                        else if (b == jtke_pkg::CH_BSLASH) escaped = 1'b1;
                        if (value_len + 1 < usable() && value_len < BUF_MAX)
                        begin
                            value_buf[value_len] = b;
                            value_len++;
                        end
                    end
                end
                default: r = SCAN_FAIL;
            endcase
            return r;
        endfunction

        // note an accepted byte and queue the words it causes
        function void predict(logic [7:0] b, logic lst);
            scan_e       r;
            int unsigned lim;
            int unsigned k;
            if (!resolved)
            begin
                r = (capacity == 0) ? SCAN_FAIL : scan(b);
                if (r == SCAN_FOUND)
                begin
                    lim = (usable() > 0) ? usable() - 1 : 0;
                    k = (value_len > lim) ? lim : value_len;
                    for (int i = 0; i < k; i++)
                        add_word(jtke_pkg::KIND_CHAR, value_buf[i], jtke_pkg::STAT_FOUND,
                                 1'b0);
                    add_word(jtke_pkg::KIND_STATUS, 8'h00, jtke_pkg::STAT_FOUND, 1'b1);
                    resolved = 1'b1;
                end
                else if (r == SCAN_FAIL)
                begin
                    add_word(jtke_pkg::KIND_STATUS, 8'h00, jtke_pkg::STAT_NOT_FOUND, 1'b1);
                    resolved = 1'b1;
                end
            end
            if (lst)
            begin
                if (!resolved)
                    add_word(jtke_pkg::KIND_STATUS, 8'h00, jtke_pkg::STAT_NOT_FOUND, 1'b1);
                restart();
            end
        endfunction

        // compare an accepted output word with the oldest expected one
        function void check_word(word_t got);
            word_t want;
            if (expected_words.size() == 0)
            begin
                $error("unexpected word: kind %0d char %02h status %0d end %0d",
                       got.kind, got.ch, got.code, got.closing);
                errors++;
                return;
            end
            want = expected_words.pop_front();
            if (got.kind !== want.kind)
            begin
                $error("out_kind: expected %0d, got %0d", want.kind, got.kind);
                errors++;
            end
            if (got.ch !== want.ch)
            begin
                $error("value_char: expected %02h, got %02h", want.ch, got.ch);
                errors++;
            end
            if (got.code !== want.code)
            begin
                $error("status_code: expected %0d, got %0d", want.code, got.code);
                errors++;
            end
            if (got.closing !== want.closing)
            begin
                $error("run_end: expected %0d, got %0d", want.closing, got.closing);
                errors++;
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [jtke_pkg::CNT_W-1:0] cfg_data;
    logic [7:0]                frame_q[$];
    bit                        steady = 1'b0;
    int                        cycles = 0;
    int                        bytes_sent = 0;
    extract_scoreboard         sb = new();

    jtke_in_if  in_ch();
    jtke_out_if out_ch();

    json_type_key_extractor #(
        .VALUE_MAX(BUF_MAX),
        .DEPTH_MAX(NEST_MAX)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_ch    (in_ch),
        .out_ch   (out_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // output side: check accepted words, stall at random
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_word({out_ch.out_kind, out_ch.value_char, out_ch.status_code,
                           out_ch.run_end});
        out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // offer one byte, with a random gap ahead of it, and wait for the handshake
    task automatic push_byte(input logic [7:0] b, input logic lst);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.in_byte <= b;
        in_ch.last_byte <= lst;
        do @(posedge clk); while (!in_ch.ready);
        sb.predict(b, lst);
        bytes_sent++;
    endtask

    task automatic send_frame(input bit close_frame);
        for (int i = 0; i < frame_q.size(); i++)
            push_byte(frame_q[i], close_frame && i == frame_q.size() - 1);
        frame_q.delete();
    endtask

    // stop input and let every expected word out
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [jtke_pkg::CNT_W-1:0] v);
        settle();
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        sb.capacity = v;
        cfg_we <= 1'b0;
    endtask

    // frame building
    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            frame_q.push_back(s[i]);
    endfunction

    function automatic void push_run(input logic [7:0] b, input int n);
        repeat (n) frame_q.push_back(b);
    endfunction

    function automatic void push_blank();
        int n;
        n = ($urandom_range(3) > 1) ? $urandom_range(1, 2) : 0;
        repeat (n)
        begin
            case ($urandom_range(3))
                0: frame_q.push_back(CH_SPACE);
                1: frame_q.push_back(CH_TAB);
                2: frame_q.push_back(CH_LF);
                default: frame_q.push_back(CH_CR);
            endcase
        end
    endfunction

    function automatic logic [7:0] plain_char();
        logic [7:0] b;
        do b = 8'($urandom_range(8'h20, 8'h7e));
        while (b == jtke_pkg::CH_QUOTE || b == jtke_pkg::CH_BSLASH);
        return b;
    endfunction

    // string body with escape pairs and the odd raw byte
    function automatic void push_body(input int n);
        int         r;
        logic [7:0] b;
        repeat (n)
        begin
            r = $urandom_range(99);
            if (r < 10)
            begin
                frame_q.push_back(jtke_pkg::CH_BSLASH);
                frame_q.push_back(8'($urandom_range(255)));
            end
            else if (r < 15)
            begin
                do b = 8'($urandom_range(255));
                while (b == jtke_pkg::CH_QUOTE || b == jtke_pkg::CH_BSLASH);
                frame_q.push_back(b);
            end
            else
                frame_q.push_back(plain_char());
        end
    endfunction

    function automatic void push_key(input bit is_type);
        if (is_type)
            push_text("\"type\"");
        else
        begin
            case ($urandom_range(7))
                0: push_text("\"typ\"");
                1: push_text("\"types\"");
                2: push_text("\"Type\"");
                3: push_text("\"t\\ype\"");
                4: push_text("\"\"");
                5: push_text("\"ty\\\"pe\"");
                default:
                begin
                    frame_q.push_back(jtke_pkg::CH_QUOTE);
                    push_body($urandom_range(1, 6));
                    frame_q.push_back(jtke_pkg::CH_QUOTE);
                end
            endcase
        end
    endfunction

    // nested value; brackets of the other kind are not counted by the block
    function automatic void push_nest(input bit brace, input int lvl);
        frame_q.push_back(brace ? jtke_pkg::CH_LBRACE : jtke_pkg::CH_LBRACK);
        repeat ($urandom_range(3))
        begin
            case ($urandom_range(4))
                0:
                begin
                    if (lvl < 3) push_nest($urandom_range(1), lvl + 1);
                    else push_text("7");
                end
                1:
                begin
                    frame_q.push_back(jtke_pkg::CH_QUOTE);
                    push_body($urandom_range(3));
                    if ($urandom_range(1))
                        frame_q.push_back(brace ? jtke_pkg::CH_RBRACE : jtke_pkg::CH_RBRACK);
                    frame_q.push_back(jtke_pkg::CH_QUOTE);
                end
                2: push_text("42");
                3: frame_q.push_back(jtke_pkg::CH_COMMA);
                default: frame_q.push_back(brace ? jtke_pkg::CH_RBRACK : jtke_pkg::CH_RBRACE);
            endcase
        end
        frame_q.push_back(brace ? jtke_pkg::CH_RBRACE : jtke_pkg::CH_RBRACK);
    endfunction

    function automatic void push_value();
        case ($urandom_range(4))
            0, 1:
            begin
                frame_q.push_back(jtke_pkg::CH_QUOTE);
                push_body($urandom_range(5));
                frame_q.push_back(jtke_pkg::CH_QUOTE);
            end
            2: push_nest($urandom_range(1), 1);
            3:
            begin
                case ($urandom_range(3))
                    0: push_text("12");
                    1: push_text("true");
                    2: push_text("-3.5");
                    default: push_text("null");
                endcase
            end
            default:
            begin
                repeat ($urandom_range(1, 3)) frame_q.push_back(plain_char());
            end
        endcase
    endfunction

    function automatic void push_type_value();
        int r;
        int n;
        r = $urandom_range(99);
        if (r < 80) n = $urandom_range(6);
        else if (r < 95) n = $urandom_range(7, 31);
        else n = $urandom_range(32, 40);
        frame_q.push_back(jtke_pkg::CH_QUOTE);
        push_body(n);
        frame_q.push_back(jtke_pkg::CH_QUOTE);
    endfunction

    // a mostly well-formed object, usually with the type member somewhere in it
    function automatic void build_frame();
        int n;
        int at;
        bit has_type;
        frame_q.delete();
        if ($urandom_range(99) < 20) push_blank();
        frame_q.push_back(jtke_pkg::CH_LBRACE);
        push_blank();
        n = $urandom_range(1, 4);
        at = $urandom_range(n - 1);
        has_type = $urandom_range(99) < 85;
        for (int i = 0; i < n; i++)
        begin
            if (i > 0)
            begin
                push_blank();
                if ($urandom_range(99) < 90) frame_q.push_back(jtke_pkg::CH_COMMA);
                else frame_q.push_back(CH_SPACE);
                push_blank();
            end
            push_key(has_type && i == at);
            push_blank();
            frame_q.push_back(jtke_pkg::CH_COLON);
            push_blank();
            if (has_type && i == at && $urandom_range(99) < 90) push_type_value();
            else push_value();
        end
        push_blank();
        frame_q.push_back(jtke_pkg::CH_RBRACE);
        if ($urandom_range(99) < 20)
            repeat ($urandom_range(1, 3)) frame_q.push_back(8'($urandom_range(255)));
    endfunction

    // directed frames: shapes, near-miss keys, malformed input, capacity corners
    task automatic run_directed();
        // basic hit at reset capacity
        push_text("{\"type\":\"ab\"}");
        send_frame(1'b1);
        write_capacity(6'd32);

        // whitespace, skipped values of every kind, missing comma, escaped quote in value
        push_text(" {\t\"id\" : 12 ,\"x\":\"q\\\"}\",\n\"n\":{\"a\":[1,{\"b\":\"}\"}]},");
        push_text("\"l\":[[1],2] \"type\"\r: \"v\\\"x\"}");
        send_frame(1'b1);

        // keys that must not match, closing brace after a value is malformed
        push_text("{\"typ\":1,\"types\":2,\"t\\ype\":3,\"Type\":4,\"\":\"type\"}");
        send_frame(1'b1);

        // malformed first byte, rest of frame ignored
        push_text("x{\"type\":\"a\"}");
        send_frame(1'b1);

        // frame ends inside the value
        push_text("{\"type\":\"abc");
        send_frame(1'b1);

        // extreme byte values inside the value
        push_text("{\"type\":\"");
        frame_q.push_back(8'h00);
        frame_q.push_back(8'hff);
        frame_q.push_back(8'h80);
        frame_q.push_back(8'h7f);
        push_text("\"}");
        send_frame(1'b1);

        // non-string type value, empty value, bad byte where a key should start, frames that end early
        push_text("{\"type\":5}");
        send_frame(1'b1);
        push_text("{\"a\":}");
        send_frame(1'b1);
        push_text("{5}");
        send_frame(1'b1);
        push_text("{");
        send_frame(1'b1);
        push_text(" ");
        send_frame(1'b1);

        // truncation at full capacity and above the buffer size
        push_text("{\"type\":\"");
        for (int i = 0; i < 40; i++) frame_q.push_back(8'(8'h61 + i % 26));
        push_text("\"}");
        send_frame(1'b1);
        write_capacity(6'd63);
        push_text("{\"type\":\"");
        for (int i = 0; i < 40; i++) frame_q.push_back(8'(8'h41 + i % 26));
        push_text("\"}");
        send_frame(1'b1);

        // tiny capacities
        write_capacity(6'd2);
        push_text("{\"type\":\"xyz\"}");
        send_frame(1'b1);
        write_capacity(6'd1);
        push_text("{\"type\":\"xyz\"}");
        send_frame(1'b1);
        write_capacity(6'd0);
        push_text("{\"type\":\"a\"}");
        send_frame(1'b1);

        // capacity lowered, then raised, in the middle of a capture
        write_capacity(6'd32);
        push_text("{\"type\":\"abcdef");
        send_frame(1'b0);
        write_capacity(6'd3);
        push_text("gh\"}");
        send_frame(1'b1);
        push_text("{\"type\":\"abc");
        send_frame(1'b0);
        write_capacity(6'd32);
        push_text("de\"}");
        send_frame(1'b1);

        // nesting at the depth limit, then one deeper
        push_text("{\"a\":");
        push_run(jtke_pkg::CH_LBRACK, NEST_MAX);
        push_run(jtke_pkg::CH_RBRACK, NEST_MAX);
        push_text(",\"type\":\"d\"}");
        send_frame(1'b1);
        push_text("{\"a\":");
        push_run(jtke_pkg::CH_LBRACE, NEST_MAX + 1);
        send_frame(1'b1);
    endtask

    // random frames: mostly well formed, some damaged, some noise
    task automatic run_random();
        int         start_bytes;
        int         frames;
        int         r;
        int         keep;
        logic [5:0] cap;
        start_bytes = bytes_sent;
        frames = 0;
        while (bytes_sent - start_bytes < 180)
        begin
            steady = (frames >= 4 && frames < 10);
            if (frames % 5 == 4)
            begin
                case ($urandom_range(9))
                    0: cap = 6'd0;
                    1: cap = 6'd1;
                    2: cap = 6'd2;
                    3: cap = 6'($urandom_range(3, 10));
                    4: cap = 6'd63;
                    5: cap = 6'($urandom_range(33, 62));
                    default: cap = 6'd32;
                endcase
                write_capacity(cap);
            end
            r = $urandom_range(99);
            if (r < 10)
            begin
                frame_q.delete();
                repeat ($urandom_range(1, 8)) frame_q.push_back(8'($urandom_range(255)));
            end
            else
            begin
                build_frame();
                if (r < 25)
                    frame_q[$urandom_range(frame_q.size() - 1)] = 8'($urandom_range(255));
                else if (r < 35)
                begin
                    keep = $urandom_range(1, frame_q.size());
                    while (frame_q.size() > keep) void'(frame_q.pop_back());
                end
            end
            send_frame(1'b1);
            frames++;
        end
        steady = 1'b0;
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_data <= '0;
        in_ch.valid <= 1'b0;
        in_ch.in_byte <= '0;
        in_ch.last_byte <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();
        run_random();

        settle();
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
